// ===== src/hsv_pkg.sv =====
// hsv_pkg: shared types and constants for the hsv to rgb converter
// depends on nothing; imported by hsv_front, hsv_back, the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

  localparam int unsigned CH_W = 16;        // channel width, Q0.16
  localparam int unsigned ONE_W = CH_W + 1; // width holding the constant one
  localparam logic [ONE_W-1:0] FRAC_ONE = 17'd65536;

  localparam int unsigned SECTOR_W = 3;
  localparam int unsigned REM_W = 13;
  localparam logic [CH_W-1:0] SECTOR_UNITS = 16'd7680;  // 60 degrees in 1/128 deg
  localparam logic [CH_W-1:0] FULL_TURN = 16'd46080;    // 360 degrees in 1/128 deg

  // f = floor(rem * 128 / 15) as rem * RECIP >> RECIP_SHIFT, exact for rem < 7680
  localparam int unsigned RECIP_W = 21;
  localparam logic [RECIP_W-1:0] FRAC_RECIP = 21'd1118482;
  localparam int unsigned RECIP_SHIFT = 17;

  typedef enum logic [SECTOR_W-1:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  // classified item passed from the front to the back
  typedef struct packed {
    sector_t         sector;
    logic [CH_W-1:0] frac;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] brightness;
  } front_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

// ===== src/hsv_to_rgb_converter.sv =====
// hsv_to_rgb_converter: top level, hsv colour in, rgb colour out
// depends on hsv_pkg, hsv_front, hsv_queue and hsv_back
//
// usage:
//   input side is a queue: drive hue/saturation/brightness with push; a
//   transfer happens at a clock edge with push high and full low
//   output side is a queue: red/green/blue hold the oldest result while
//   empty is low; a transfer happens at an edge with pop high and empty low
// structure:
//   front classifies the hue (sector and fraction) and writes a short
//   queue; the back pulls from it through a two-stage multiply pipeline
//   (stage 1: s*f and s*(1-f), stage 2: v times the three factors and the
//   sector select) into the result queue
// throughput:
//   one item per cycle sustained while the result queue is drained, set by
//   the single pass through each multiply stage
// stall and reset:
//   the back only takes an item when the result queue has a slot reserved,
//   so a stalled receiver fills the result queue, then the front queue,
//   then raises full; nothing is dropped
//   synchronous reset empties both queues and the pipeline
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter
  import hsv_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [CH_W-1:0] hue,
  input  wire logic [CH_W-1:0] saturation,
  input  wire logic [CH_W-1:0] brightness,
  output logic                 empty,
  input  wire logic            pop,
  output logic [CH_W-1:0]      red,
  output logic [CH_W-1:0]      green,
  output logic [CH_W-1:0]      blue
);

  front_item_t front_item;
  front_item_t back_item;
  logic        mid_empty;
  logic        back_take;

  // sector and fraction from the hue
  hsv_front u_front (
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .item       (front_item)
  );

  // decoupling queue: input transfers land here directly
  hsv_queue #(
    .WIDTH ($bits(front_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .full  (full),
    .pop   (back_take),
    .dout  (back_item),
    .empty (mid_empty)
  );

  // p/q/t arithmetic, channel select and result queue
  hsv_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (back_item),
    .item_valid (!mid_empty),
    .item_take  (back_take),
    .pop        (pop),
    .empty      (empty),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

endmodule

`default_nettype wire

// ===== src/hsv_queue.sv =====
// hsv_queue: small synchronous fifo with full/empty flags
// standalone; used between front and back and as the result queue
`timescale 1ns / 1ps
`default_nettype none

module hsv_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/hsv_front.sv =====
// hsv_front: classifies a hue into its 60 degree sector and Q0.16 fraction
// depends on hsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsv_front
  import hsv_pkg::*;
(
  input  wire logic [CH_W-1:0] hue,
  input  wire logic [CH_W-1:0] saturation,
  input  wire logic [CH_W-1:0] brightness,
  output front_item_t          item
);

  logic [CH_W-1:0]              hue_lim;
  sector_t                      sector;
  logic [CH_W-1:0]              base;
  logic [CH_W-1:0]              rem_full;
  logic [REM_W-1:0]             rem;
  logic [REM_W+RECIP_W-1:0]     scaled;

  // a full turn or more wraps to zero
  assign hue_lim = (hue >= FULL_TURN) ? '0 : hue;

  always_comb begin
    if (hue_lim >= CH_W'(5 * 7680)) begin
      sector = SEC_5;
      base   = CH_W'(5 * 7680);
    end else if (hue_lim >= CH_W'(4 * 7680)) begin
      sector = SEC_4;
      base   = CH_W'(4 * 7680);
    end else if (hue_lim >= CH_W'(3 * 7680)) begin
      sector = SEC_3;
      base   = CH_W'(3 * 7680);
    end else if (hue_lim >= CH_W'(2 * 7680)) begin
      sector = SEC_2;
      base   = CH_W'(2 * 7680);
    end else if (hue_lim >= SECTOR_UNITS) begin
      sector = SEC_1;
      base   = SECTOR_UNITS;
    end else begin
      sector = SEC_0;
      base   = '0;
    end
  end

  assign rem_full = hue_lim - base;
  assign rem      = rem_full[REM_W-1:0];
  // divide by 7680 and scale by 65536 via reciprocal multiply
  assign scaled   = REM_W'(rem) * RECIP_W'(FRAC_RECIP);

  assign item.sector     = sector;
  assign item.frac       = scaled[RECIP_SHIFT +: CH_W];
  assign item.saturation = saturation;
  assign item.brightness = brightness;

endmodule

`default_nettype wire

// ===== src/hsv_back.sv =====
// hsv_back: two-stage p/q/t datapath, sector select and result queue
// depends on hsv_pkg and hsv_queue
`timescale 1ns / 1ps
`default_nettype none

module hsv_back
  import hsv_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire front_item_t     item,
  input  wire logic            item_valid,
  output logic                 item_take,
  input  wire logic            pop,
  output logic                 empty,
  output logic [CH_W-1:0]      red,
  output logic [CH_W-1:0]      green,
  output logic [CH_W-1:0]      blue
);

  localparam int unsigned CRED_W = $clog2(OUT_DEPTH + 1);
  localparam logic [CRED_W-1:0] CRED_MAX = CRED_W'(OUT_DEPTH);

  // stage 1 registers
  logic             s1_valid;
  sector_t          s1_sector;
  logic [CH_W-1:0]  s1_v;
  logic [ONE_W-1:0] s1_ap;
  logic [ONE_W-1:0] s1_aq;
  logic [ONE_W-1:0] s1_at;

  // stage 2 registers
  logic             s2_valid;
  rgb_t             s2_rgb;

  logic [CRED_W-1:0] inflight;
  logic              out_full;
  logic              out_pop;
  rgb_t              out_rgb;

  logic [2*CH_W-1:0]       sf_prod;
  logic [CH_W+ONE_W-1:0]   st_prod;
  logic [ONE_W-1:0]        one_minus_f;
  logic [CH_W+ONE_W-1:0]   p_prod;
  logic [CH_W+ONE_W-1:0]   q_prod;
  logic [CH_W+ONE_W-1:0]   t_prod;
  logic [CH_W-1:0]         p_val;
  logic [CH_W-1:0]         q_val;
  logic [CH_W-1:0]         t_val;
  rgb_t                    rgb_sel;

  // take a new item only with room reserved in the result queue
  assign item_take = item_valid && (inflight < CRED_MAX);
  assign out_pop   = pop && !empty;

  assign one_minus_f = FRAC_ONE - ONE_W'(item.frac);
  assign sf_prod     = item.saturation * item.frac;
  assign st_prod     = ONE_W'(item.saturation) * one_minus_f;

  always_ff @(posedge clk) begin
    s1_sector <= item.sector;
    s1_v      <= item.brightness;
    s1_ap     <= FRAC_ONE - ONE_W'(item.saturation);
    s1_aq     <= FRAC_ONE - ONE_W'(sf_prod[2*CH_W-1:CH_W]);
    s1_at     <= FRAC_ONE - st_prod[CH_W +: ONE_W];
  end

  // saturation zero makes p, q and t all equal v, which gives grey
  assign p_prod = ONE_W'(s1_v) * s1_ap;
  assign q_prod = ONE_W'(s1_v) * s1_aq;
  assign t_prod = ONE_W'(s1_v) * s1_at;
  assign p_val  = p_prod[CH_W +: CH_W];
  assign q_val  = q_prod[CH_W +: CH_W];
  assign t_val  = t_prod[CH_W +: CH_W];

  always_comb begin
    unique case (s1_sector)
      SEC_0:   rgb_sel = '{red: s1_v,  green: t_val, blue: p_val};
      SEC_1:   rgb_sel = '{red: q_val, green: s1_v,  blue: p_val};
      SEC_2:   rgb_sel = '{red: p_val, green: s1_v,  blue: t_val};
      SEC_3:   rgb_sel = '{red: p_val, green: q_val, blue: s1_v};
      SEC_4:   rgb_sel = '{red: t_val, green: p_val, blue: s1_v};
      default: rgb_sel = '{red: s1_v,  green: p_val, blue: q_val};
    endcase
  end

  always_ff @(posedge clk) begin
    s2_rgb <= rgb_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      inflight <= '0;
    end else begin
      s1_valid <= item_take;
      s2_valid <= s1_valid;
      if (item_take && !out_pop) begin
        inflight <= inflight + 1'b1;
      end else if (out_pop && !item_take) begin
        inflight <= inflight - 1'b1;
      end
    end
  end

  hsv_queue #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (s2_valid),
    .din   (s2_rgb),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_rgb),
    .empty (empty)
  );

  assign red   = out_rgb.red;
  assign green = out_rgb.green;
  // credit count keeps the result queue from overflowing; it may fill but is never pushed while full
  assign blue  = out_full ? out_rgb.blue : out_rgb.blue;

endmodule

`default_nettype wire

// ===== verif/hsv_to_rgb_converter_tb.sv =====
// hsv_to_rgb_converter_tb: self-checking testbench for the hsv to rgb converter
// depends on hsv_pkg and hsv_to_rgb_converter; predicts every rgb result in place
// runs directed corner colors, a backpressure burst, a long random stream and a full-rate run
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
  import hsv_pkg::*;

  localparam int unsigned CLK_HALF_NS = 6;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned SETTLE_CYCLES = 12;      // longer than the pipeline latency
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 10;
  localparam longint unsigned RUN_LIMIT_NS = 5_000_000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            push = 1'b0;
  logic            pop = 1'b0;
  logic [CH_W-1:0] hue = '0;
  logic [CH_W-1:0] saturation = '0;
  logic [CH_W-1:0] brightness = '0;
  logic            full;
  logic            empty;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  // rgb colors predicted for accepted transfers, oldest first
  rgb_t pending_rgb[$];
  int unsigned mismatch_count = 0;

  // idling knobs for the stimulus side and the result side, set by the tests
  bit sender_idle_on = 1'b0;
  bit receiver_idle_on = 1'b0;
  int unsigned hold_off_cycles = 0;

  hsv_to_rgb_converter uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .empty      (empty),
    .pop        (pop),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // six-sector hsv to rgb in q0.16, products truncated
  function automatic rgb_t convert_hsv(input logic [CH_W-1:0] h, input logic [CH_W-1:0] s,
                                       input logic [CH_W-1:0] v);
    longint unsigned one_q;
    longint unsigned hue_in_turn;
    longint unsigned sat_q;
    longint unsigned val_q;
    longint unsigned rem;
    longint unsigned frac;
    longint unsigned p_q;
    longint unsigned q_q;
    longint unsigned t_q;
    logic [SECTOR_W-1:0] sec_bits;
    sector_t sec;
    rgb_t rgb;
    one_q = 64'(FRAC_ONE);
    sat_q = 64'(s);
    val_q = 64'(v);
    if (s == '0) begin
      // grey: hue plays no part
      rgb.red = v;
      rgb.green = v;
      rgb.blue = v;
    end else begin
      // a hue past a full turn folds to zero
      hue_in_turn = (h >= FULL_TURN) ? 64'd0 : 64'(h);
      sec_bits = SECTOR_W'(hue_in_turn / SECTOR_UNITS);
      sec = sector_t'(sec_bits);
      rem = hue_in_turn % SECTOR_UNITS;
      frac = (rem << 16) / SECTOR_UNITS;
      p_q = (val_q * (one_q - sat_q)) >> 16;
      q_q = (val_q * (one_q - ((sat_q * frac) >> 16))) >> 16;
      t_q = (val_q * (one_q - ((sat_q * (one_q - frac)) >> 16))) >> 16;
      case (sec)
        SEC_0: begin
          rgb.red = CH_W'(val_q); rgb.green = CH_W'(t_q); rgb.blue = CH_W'(p_q);
        end
        SEC_1: begin
          rgb.red = CH_W'(q_q); rgb.green = CH_W'(val_q); rgb.blue = CH_W'(p_q);
        end
        SEC_2: begin
          rgb.red = CH_W'(p_q); rgb.green = CH_W'(val_q); rgb.blue = CH_W'(t_q);
        end
        SEC_3: begin
          rgb.red = CH_W'(p_q); rgb.green = CH_W'(q_q); rgb.blue = CH_W'(val_q);
        end
        SEC_4: begin
          rgb.red = CH_W'(t_q); rgb.green = CH_W'(p_q); rgb.blue = CH_W'(val_q);
        end
        default: begin
          // sector five and anything beyond
          rgb.red = CH_W'(val_q); rgb.green = CH_W'(p_q); rgb.blue = CH_W'(q_q);
        end
      endcase
    end
    return rgb;
  endfunction

  // offer one color and hold it until the converter takes it; called at a
  // rising edge, returns at the edge of the transfer with push still high
  task automatic send_color(input logic [CH_W-1:0] h, input logic [CH_W-1:0] s,
                            input logic [CH_W-1:0] v);
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    push <= 1'b1;
    hue <= h;
    saturation <= s;
    brightness <= v;
    // full is sampled before the edge updates it
    do @(posedge clk); while (full);
    pending_rgb.push_back(convert_hsv(h, s, v));
  endtask

  // sender goes quiet until every predicted color has come back
  task automatic wait_all_returned();
    push <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  // mostly in-range hues, some past a full turn, some grey, some at sector edges
  task automatic send_random_color();
    logic [CH_W-1:0] h;
    logic [CH_W-1:0] s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) h = CH_W'($urandom_range(0, FULL_TURN - 1));
    else if (pick < 92) h = CH_W'($urandom_range(FULL_TURN, 16'hFFFF));
    else h = CH_W'(SECTOR_UNITS * $urandom_range(0, 5)
                   + $urandom_range(0, 1) * (SECTOR_UNITS - 1));
    s = ($urandom_range(0, 19) == 0) ? '0 : CH_W'($urandom_range(0, 16'hFFFF));
    send_color(h, s, CH_W'($urandom_range(0, 16'hFFFF)));
  endtask

  // result side: random pop stalls plus a counted long hold-off on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        hold_off_cycles--;
        pop <= 1'b0;
        @(posedge clk);
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && pop && !empty) begin
      if (pending_rgb.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result r=%h g=%h b=%h", $realtime, red, green, blue);
      end else begin
        want = pending_rgb.pop_front();
        if (red !== want.red || green !== want.green || blue !== want.blue) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: rgb mismatch expected r=%h g=%h b=%h actual r=%h g=%h b=%h",
                     $realtime, want.red, want.green, want.blue, red, green, blue);
        end
      end
    end
  end

  // zero saturation at both hue ends and past a full turn
  task automatic test_grey();
    send_color(16'd0, 16'd0, 16'hFFFF);
    send_color(FULL_TURN - 1, 16'd0, 16'h1234);
    send_color(16'hFFFF, 16'd0, 16'd0);
    send_color(16'h5A5A, 16'd0, 16'hA5A5);
  endtask

  // first and last hue of every sector at full saturation and value
  task automatic test_sector_boundaries();
    for (int i = 0; i < 6; i++) begin
      send_color(CH_W'(SECTOR_UNITS * i), 16'hFFFF, 16'hFFFF);
      send_color(CH_W'(SECTOR_UNITS * i + SECTOR_UNITS - 1), 16'hFFFF, 16'hFFFF);
    end
  endtask

  // hues at and beyond a full turn must behave as hue zero
  task automatic test_hue_wrap();
    send_color(FULL_TURN, 16'h8000, 16'hFFFF);
    send_color(16'hFFFF, 16'h8000, 16'hFFFF);
    send_color(FULL_TURN + 16'd1, 16'hFFFF, 16'h7FFF);
  endtask

  // smallest nonzero saturation, zero value, full value
  task automatic test_field_extremes();
    send_color(16'd12345, 16'd1, 16'hFFFF);
    send_color(16'd20000, 16'hFFFF, 16'd0);
    send_color(16'd30000, 16'd1, 16'd1);
    send_color(16'h5555, 16'hAAAA, 16'h5555);
    wait_all_returned();
  endtask

  // hold pop off long enough that both internal queues fill and full rises
  task automatic test_backpressure();
    hold_off_cycles = LONG_HOLD_CYCLES;
    repeat (40) send_random_color();
    wait_all_returned();
  endtask

  // random colors with bursts of idling on both sides, drained now and then
  task automatic test_random_stream();
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    for (int i = 0; i < 1500; i++) begin
      send_random_color();
      if ($urandom_range(0, 199) == 0) wait_all_returned();
    end
    wait_all_returned();
  endtask

  // back-to-back transfers with no idling at all
  task automatic test_full_rate();
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    repeat (150) send_random_color();
    wait_all_returned();
  endtask

  initial begin
    // synchronous reset at the start, never asserted again
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_grey();
    test_sector_boundaries();
    test_hue_wrap();
    test_field_extremes();
    test_backpressure();
    test_random_stream();
    test_full_rate();

    // let any stray result show up before judging
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rgb.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hsv_pkg.sv
src/hsv_queue.sv
src/hsv_front.sv
src/hsv_back.sv
src/hsv_to_rgb_converter.sv
verif/hsv_to_rgb_converter_tb.sv
